// ===== sv/dlfb_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfb_pkg
// types, codes and helpers for the dense layer forward/backward core
// ----------------------------------------------------------------------------
package dlfb_pkg;

	localparam int CNT_W = 7;
	localparam int CFG_W = 16;

	localparam logic [2:0] FN_WEIGHT = 3'd0;
	localparam logic [2:0] FN_BIAS   = 3'd1;
	localparam logic [2:0] FN_FWD    = 3'd2;
	localparam logic [2:0] FN_ACT    = 3'd3;
	localparam logic [2:0] FN_GRAD   = 3'd4;

	localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
	localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
	localparam logic [1:0] CFG_LEARN_RATE   = 2'd2;

	typedef struct packed {
		logic [2:0]          func;
		logic [5:0]          row;
		logic [5:0]          column;
		logic signed [15:0]  value;
		logic                last;
	} req_t;

	typedef struct packed {
		logic signed [15:0]  result_value;
		logic [5:0]          result_index;
		logic                kind;
		logic                status;
		logic                final_res;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_BIAS_RD,
		ST_BIAS_WR,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_ERR
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
		logic signed [15:0] r;
		if (v > 50'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -50'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/dense_layer_forward_backward_core.sv =====
// ----------------------------------------------------------------------------
// dense_layer_forward_backward_core
// fully connected layer, Q4.12, forward pass and sgd backward pass
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  request  | req_valid, req_stall, req        | in
//  result   | res_valid, res_stall, res        | out
//  config   | cfg_we, cfg_index, cfg_data      | in
//
//  weight and bias writes and backward activations need no run of the pipe
//  forward or gradient element: loop over a weight column or row, one entry
//  per cycle through a read-modify-write pipe; the loop length is OUT_MAX
//  (forward) or IN_MAX (gradient) on the first element of a run; a row
//  update adds a bias read state and a bias write state
//  results leave one at a time, each read then loaded, through a single output register
//  reset clears control, counts, bias valid bits; no clearing pass
//  a stalled result holds only the emit loop and the error state; requests wait in idle
// ----------------------------------------------------------------------------
module dense_layer_forward_backward_core #(
	parameter int IN_MAX    = 64,
	parameter int OUT_MAX   = 64,
	parameter int FRAC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  dlfb_pkg::req_t                      req,
	output logic                                res_valid,
	input  logic                                res_stall,
	output dlfb_pkg::res_t                      res,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [dlfb_pkg::CFG_W-1:0]          cfg_data
);
	import dlfb_pkg::*;

	localparam int IW     = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
	localparam int OW     = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
	localparam int AMAX   = (IN_MAX > OUT_MAX) ? IN_MAX : OUT_MAX;
	localparam int AW     = (AMAX > 1) ? $clog2(AMAX) : 1;
	localparam int WDEPTH = 1 << (OW + IW);

	// memories
	logic signed [15:0] wmem [0:WDEPTH-1];
	logic signed [39:0] amem [0:AMAX-1];
	logic signed [15:0] bmem [0:OUT_MAX-1];
	logic signed [15:0] xmem [0:IN_MAX-1];
	logic [OUT_MAX-1:0] bvalid_q;

	// config
	logic [CNT_W-1:0] input_count_q, output_count_q;
	logic [15:0]      lr_q;
	logic [CNT_W-1:0] n_in, n_out;

	// run state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, act_cnt_q;
	logic             run_bwd_q, act_done_q;

	// item registers
	logic [CNT_W-1:0]   elem_q, lim_q, len_q, idx_q, e_q;
	logic               bwd_q, first_q, last_q, err_q, upd_q, kind_q;
	logic signed [15:0] val_q;

	// item decode
	logic             accept, is_fwd, is_grad, is_act, acts_ok, grad_act;
	logic [CNT_W-1:0] c_cur, c_inc, lim_d, len_d, ac_cur, ac_inc;
	logic             err_d, act_err;

	// pipeline
	logic               v_s1, v_s2, v_s3, en_s1, en_s2;
	logic [CNT_W-1:0]   idx_s1, idx_s2, idx_s3;
	logic signed [15:0] w_rd_s1, b_rd_s1, x_rd_s1, w_s2, w_s3;
	logic               b_ok_s1;
	logic signed [39:0] acc_rd_s1, seed_s2;
	logic signed [31:0] p1_s2, p2_s2;
	logic signed [48:0] p3_s3;
	logic signed [32:0] bp_q;
	logic signed [15:0] b_val;
	logic signed [39:0] acc_new;
	logic signed [49:0] wstep, bstep;
	logic signed [40:0] rnd;

	// control strobes
	logic                w_we, b_we, rd_acc, rd_bias, load, out_free, emit_fin;
	logic [OW+IW-1:0]    w_wa, w_ra;
	logic signed [15:0]  w_wd, b_wd;
	logic [OW-1:0]       b_wa, b_ra;
	logic [AW-1:0]       a_ra;
	logic [CNT_W-1:0]    e_lim;
	res_t                res_d;
	logic                res_valid_q;
	res_t                res_q;

	assign n_in  = (input_count_q > CNT_W'(IN_MAX)) ? CNT_W'(IN_MAX) : input_count_q;
	assign n_out = (output_count_q > CNT_W'(OUT_MAX)) ? CNT_W'(OUT_MAX) : output_count_q;

	// item decode
	always_comb begin
		accept  = req_valid && !req_stall;
		is_fwd  = req.func == FN_FWD;
		is_grad = req.func == FN_GRAD;
		is_act  = req.func == FN_ACT;
		acts_ok = act_done_q && (act_cnt_q == n_in) && (n_in != '0);
		if (is_fwd) begin
			c_cur = run_bwd_q ? '0 : cnt_q;
		end else begin
			c_cur = run_bwd_q ? cnt_q : '0;
		end
		c_inc    = (c_cur == '1) ? c_cur : c_cur + 1'b1;
		grad_act = acts_ok && (c_cur < n_out);
		if (is_fwd) begin
			lim_d = (c_cur < n_in) ? n_out : '0;
			len_d = (c_cur == '0) ? CNT_W'(OUT_MAX) : lim_d;
			err_d = (c_inc != n_in) || (n_in == '0) || (n_out == '0);
		end else begin
			lim_d = grad_act ? n_in : '0;
			len_d = (c_cur == '0) ? CNT_W'(IN_MAX) : lim_d;
			err_d = !acts_ok || (c_inc != n_out) || (n_out == '0);
		end
		ac_cur  = act_done_q ? '0 : act_cnt_q;
		ac_inc  = (ac_cur == '1) ? ac_cur : ac_cur + 1'b1;
		act_err = (ac_inc != n_in) || (n_in == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_fwd || is_grad) begin
						if (len_d != '0) begin
							state_d = ST_RUN;
						end else if (req.last) begin
							state_d = err_d ? ST_ERR : ST_EMIT_RD;
						end
					end else if (is_act && req.last && act_err) begin
						state_d = ST_ERR;
					end
				end
			end
			ST_RUN: begin
				if (idx_q == len_q - 1'b1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					if (upd_q) begin
						state_d = ST_BIAS_RD;
					end else if (last_q) begin
						state_d = err_q ? ST_ERR : ST_EMIT_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_BIAS_RD: state_d = ST_BIAS_WR;
			ST_BIAS_WR: begin
				if (last_q) begin
					state_d = err_q ? ST_ERR : ST_EMIT_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: begin
				if (out_free) begin
					state_d = emit_fin ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath strobes
	always_comb begin
		req_stall = state_q != ST_IDLE;
		out_free  = !res_valid_q || !res_stall;
		e_lim     = kind_q ? n_in : n_out;
		emit_fin  = (e_q + 1'b1) == e_lim;
		rd_acc    = (state_q == ST_RUN) || (state_q == ST_EMIT_RD);
		rd_bias   = (state_q == ST_RUN) || (state_q == ST_BIAS_RD);
		a_ra      = (state_q == ST_EMIT_RD) ? e_q[AW-1:0] : idx_q[AW-1:0];
		b_ra      = (state_q == ST_BIAS_RD) ? elem_q[OW-1:0] : idx_q[OW-1:0];
		w_ra      = bwd_q ? {elem_q[OW-1:0], idx_q[IW-1:0]}
		                  : {idx_q[OW-1:0], elem_q[IW-1:0]};

		b_val   = b_ok_s1 ? b_rd_s1 : 16'sd0;
		acc_new = seed_s2 + (en_s2 ? 40'(p1_s2) : 40'sd0);
		wstep   = (50'(p3_s3) + (50'sd1 <<< (FRAC_BITS + 15))) >>> (FRAC_BITS + 16);
		bstep   = (50'(bp_q) + (50'sd1 <<< 15)) >>> 16;
		rnd     = (41'(acc_rd_s1) + (41'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

		w_we = 1'b0;
		w_wa = {elem_q[OW-1:0], idx_s3[IW-1:0]};
		w_wd = sat16(50'(w_s3) - wstep);
		if (v_s3) begin
			w_we = 1'b1;
		end else if (accept && req.func == FN_WEIGHT && {1'b0, req.row} < CNT_W'(OUT_MAX)
		             && {1'b0, req.column} < CNT_W'(IN_MAX)) begin
			w_we = 1'b1;
			w_wa = {req.row[OW-1:0], req.column[IW-1:0]};
			w_wd = req.value;
		end

		b_we = 1'b0;
		b_wa = elem_q[OW-1:0];
		b_wd = sat16(50'(b_val) - bstep);
		if (state_q == ST_BIAS_WR) begin
			b_we = 1'b1;
		end else if (accept && req.func == FN_BIAS && {1'b0, req.row} < CNT_W'(OUT_MAX)) begin
			b_we = 1'b1;
			b_wa = req.row[OW-1:0];
			b_wd = req.value;
		end

		load  = 1'b0;
		res_d = '0;
		if (state_q == ST_EMIT_LD && out_free) begin
			load               = 1'b1;
			res_d.result_value = sat16(50'(rnd));
			res_d.result_index = e_q[5:0];
			res_d.kind         = kind_q;
			res_d.final_res    = emit_fin;
		end else if (state_q == ST_ERR && out_free) begin
			load            = 1'b1;
			res_d.kind      = kind_q;
			res_d.status    = 1'b1;
			res_d.final_res = 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_wa] <= w_wd;
		end
		if (v_s2) begin
			amem[idx_s2[AW-1:0]] <= acc_new;
		end
		if (b_we) begin
			bmem[b_wa] <= b_wd;
		end
		if (accept && is_act && ac_cur < CNT_W'(IN_MAX)) begin
			xmem[ac_cur[IW-1:0]] <= req.value;
		end
		w_rd_s1 <= wmem[w_ra];
		x_rd_s1 <= xmem[idx_q[IW-1:0]];
		if (rd_acc) begin
			acc_rd_s1 <= amem[a_ra];
		end
		if (rd_bias) begin
			b_rd_s1 <= bmem[b_ra];
			b_ok_s1 <= bvalid_q[b_ra];
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		en_s1  <= idx_q < lim_q;
		idx_s2 <= idx_s1;
		en_s2  <= en_s1;
		w_s2   <= w_rd_s1;
		p1_s2  <= val_q * w_rd_s1;
		p2_s2  <= val_q * x_rd_s1;
		if (!first_q) begin
			seed_s2 <= acc_rd_s1;
		end else if (bwd_q) begin
			seed_s2 <= 40'sd0;
		end else begin
			seed_s2 <= 40'(b_val) <<< FRAC_BITS;
		end
		idx_s3 <= idx_s2;
		w_s3   <= w_s2;
		p3_s3  <= p2_s2 * $signed({1'b0, lr_q});
		if (state_q == ST_BIAS_RD) begin
			bp_q <= val_q * $signed({1'b0, lr_q});
		end
		if (accept) begin
			elem_q <= c_cur;
			lim_q  <= lim_d;
			len_q  <= len_d;
			val_q  <= req.value;
			first_q <= c_cur == '0;
			err_q  <= err_d;
			last_q <= req.last;
			upd_q  <= is_grad && grad_act;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			input_count_q  <= CNT_W'(64);
			output_count_q <= CNT_W'(64);
			lr_q           <= 16'd655;
			cnt_q          <= '0;
			act_cnt_q      <= '0;
			run_bwd_q      <= 1'b0;
			act_done_q     <= 1'b0;
			bvalid_q       <= '0;
			idx_q          <= '0;
			e_q            <= '0;
			bwd_q          <= 1'b0;
			kind_q         <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_INPUT_COUNT:  input_count_q  <= cfg_data[CNT_W-1:0];
					CFG_OUTPUT_COUNT: output_count_q <= cfg_data[CNT_W-1:0];
					CFG_LEARN_RATE:   lr_q           <= cfg_data;
					default: ;
				endcase
			end
			if (b_we) begin
				bvalid_q[b_wa] <= 1'b1;
			end
			if (accept && (is_fwd || is_grad)) begin
				run_bwd_q <= is_grad;
				cnt_q     <= req.last ? '0 : c_inc;
				bwd_q     <= is_grad;
				kind_q    <= is_grad;
			end
			if (accept && is_act) begin
				kind_q <= 1'b1;
				if (req.last) begin
					act_cnt_q  <= act_err ? '0 : ac_inc;
					act_done_q <= !act_err;
				end else begin
					act_cnt_q  <= ac_inc;
					act_done_q <= 1'b0;
				end
			end
			if (state_q == ST_RUN) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
			if (state_q == ST_EMIT_LD && out_free) begin
				e_q <= e_q + 1'b1;
			end else if (state_q != ST_EMIT_RD && state_q != ST_EMIT_LD) begin
				e_q <= '0;
			end
			v_s1 <= state_q == ST_RUN;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && en_s2 && bwd_q;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	a_wb_bwd_only: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> bwd_q)
		else $error("weight write-back outside a gradient run");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> idx_q < len_q)
		else $error("loop index past loop length");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT_LD |-> e_q < e_lim)
		else $error("result index past count in use");
	a_act_done: assert property (@(posedge clk) disable iff (!arst_n)
		act_done_q |-> act_cnt_q != '0)
		else $error("complete activation vector with zero length");

endmodule
